// File: src/bgev_pkg.sv
// shared types and constants for the butterworth gain evaluator
package bgev_pkg;

    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        MODE_LOW_PASS  = 2'd0,
        MODE_HIGH_PASS = 2'd1,
        MODE_BAND_PASS = 2'd2,
        MODE_BAND_STOP = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE        = 2'd0,
        CFG_ORDER       = 2'd1,
        CFG_CUTOFF_LOW  = 2'd2,
        CFG_CUTOFF_HIGH = 2'd3
    } t_cfg_index;

    localparam logic [3:0]            ORDER_RESET       = 4'd1;
    localparam logic [CFG_DATA_W-1:0] CUTOFF_LOW_RESET  = 24'd1000;
    localparam logic [CFG_DATA_W-1:0] CUTOFF_HIGH_RESET = 24'd2000;

endpackage

// File: src/bgev_div.sv
// pipelined restoring divider, one quotient bit per stage
module bgev_div #(
    parameter int DEN_W  = 48,
    parameter int Q_BITS = 32,
    parameter int SIDE_W = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DEN_W-1:0]  i_rem,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [Q_BITS-1:0] i_num,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_BITS-1:0] o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_vld  [0:Q_BITS-1];
    logic [DEN_W-1:0]  r_rem  [0:Q_BITS-1];
    logic [DEN_W-1:0]  r_den  [0:Q_BITS-1];
    logic [Q_BITS-1:0] r_num  [0:Q_BITS-1];
    logic [Q_BITS-1:0] r_quo  [0:Q_BITS-1];
    logic [SIDE_W-1:0] r_side [0:Q_BITS-1];

    for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
        logic              in_vld;
        logic [DEN_W-1:0]  in_rem;
        logic [DEN_W-1:0]  in_den;
        logic [Q_BITS-1:0] in_num;
        logic [Q_BITS-1:0] in_quo;
        logic [SIDE_W-1:0] in_side;
        logic [DEN_W:0]    t;
        logic [DEN_W:0]    diff;
        logic              ge;
        logic [DEN_W-1:0]  n_rem;
        logic [Q_BITS-1:0] n_quo;

        if (k == 0) begin : g_first
            assign in_vld  = i_valid;
            assign in_rem  = i_rem;
            assign in_den  = i_den;
            assign in_num  = i_num;
            assign in_quo  = '0;
            assign in_side = i_side;
        end else begin : g_next
            assign in_vld  = r_vld[k-1];
            assign in_rem  = r_rem[k-1];
            assign in_den  = r_den[k-1];
            assign in_num  = r_num[k-1];
            assign in_quo  = r_quo[k-1];
            assign in_side = r_side[k-1];
        end

        always_comb begin
            t     = {in_rem, in_num[Q_BITS-1]};
            diff  = t - {1'b0, in_den};
            ge    = (t >= {1'b0, in_den});
            n_rem = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
            n_quo = {in_quo[Q_BITS-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_den[k]  <= in_den;
                r_num[k]  <= in_num << 1;
                r_quo[k]  <= n_quo;
                r_side[k] <= in_side;
            end
        end
    end

    assign o_valid = r_vld[Q_BITS-1];
    assign o_quo   = r_quo[Q_BITS-1];
    assign o_side  = r_side[Q_BITS-1];

endmodule

// File: src/butterworth_gain_evaluator_top.sv
// butterworth magnitude gain evaluator, top level
// Streaming pipeline: one frequency per cycle in, one gain per cycle out while
// the output is not stalled. Three setup stages form the ratio operands, a
// 32-stage divider yields the Q16.16 ratio, one multiplier stage per power step
// forms x^(2n), a second divider stage chain forms 2^(2G+16)/(1+x^(2n)) and one
// square root stage per result bit yields the gain. The whole pipeline holds
// while a result waits at the output, so nothing is dropped. Configuration must
// be written only while the pipeline is empty; the block does not enforce this.
module butterworth_gain_evaluator_top #(
    parameter int MAX_ORDER      = 8,
    parameter int FREQ_BITS      = 24,
    parameter int GAIN_FRAC_BITS = 15
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bgev_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bgev_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [FREQ_BITS-1:0]              i_frequency,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [GAIN_FRAC_BITS:0]           o_gain,
    output logic                              o_config_error
);

    localparam int FW   = FREQ_BITS;
    localparam int PW   = 2 * FREQ_BITS;
    localparam int G    = GAIN_FRAC_BITS;
    localparam int GW   = GAIN_FRAC_BITS + 1;
    localparam int NPOW = 2 * MAX_ORDER;
    localparam int QW2  = 2 * GAIN_FRAC_BITS + 1;
    localparam int VW   = 2 * GAIN_FRAC_BITS + 2;
    localparam int RW   = GAIN_FRAC_BITS + 2;
    localparam int TW   = GAIN_FRAC_BITS + 4;

    // configuration registers
    bgev_pkg::t_mode                 r_mode;
    logic [3:0]                      r_order;
    logic [bgev_pkg::CFG_DATA_W-1:0] r_cutoff_low;
    logic [bgev_pkg::CFG_DATA_W-1:0] r_cutoff_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= bgev_pkg::MODE_LOW_PASS;
            r_order       <= bgev_pkg::ORDER_RESET;
            r_cutoff_low  <= bgev_pkg::CUTOFF_LOW_RESET;
            r_cutoff_high <= bgev_pkg::CUTOFF_HIGH_RESET;
        end else if (i_cfg_we) begin
            unique case (bgev_pkg::t_cfg_index'(i_cfg_index))
                bgev_pkg::CFG_MODE:        r_mode <= bgev_pkg::t_mode'(i_cfg_data[1:0]);
                bgev_pkg::CFG_ORDER:       r_order <= i_cfg_data[3:0];
                bgev_pkg::CFG_CUTOFF_LOW:  r_cutoff_low <= i_cfg_data;
                bgev_pkg::CFG_CUTOFF_HIGH: r_cutoff_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic       en;
    logic       r_out_valid;
    logic [FW-1:0] fl;
    logic [FW-1:0] fh;
    logic          band;
    logic          cfg_err;
    logic [4:0]    order_cl;
    logic [5:0]    two_n;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign fl         = FW'(r_cutoff_low);
    assign fh         = FW'(r_cutoff_high);
    assign band       = (r_mode == bgev_pkg::MODE_BAND_PASS) ||
                        (r_mode == bgev_pkg::MODE_BAND_STOP);
    assign cfg_err    = (r_order == 4'd0) || (fl == '0) || (band && (fl > fh));
    assign order_cl   = ({1'b0, r_order} > 5'(MAX_ORDER)) ? 5'(MAX_ORDER) : {1'b0, r_order};
    assign two_n      = {order_cl, 1'b0};

    // stage a: products
    logic          r_a_valid;
    logic [PW-1:0] r_a_f2;
    logic [PW-1:0] r_a_f02;
    logic [PW-1:0] r_a_fb;
    logic [FW-1:0] r_a_f;
    logic          r_a_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_f2  <= PW'(i_frequency) * PW'(i_frequency);
            r_a_f02 <= PW'(fl) * PW'(fh);
            r_a_fb  <= PW'(i_frequency) * PW'(FW'(fh - fl));
            r_a_f   <= i_frequency;
            r_a_err <= cfg_err;
        end
    end

    // stage b: operand select
    logic          r_b_valid;
    logic [PW-1:0] r_b_num;
    logic [PW-1:0] r_b_den;
    logic          r_b_kill;
    logic          r_b_err;
    logic [PW-1:0] n_b_num;
    logic [PW-1:0] n_b_den;
    logic          n_b_zero;
    logic [PW-1:0] b_diff;

    always_comb begin
        b_diff   = (r_a_f2 >= r_a_f02) ? (r_a_f2 - r_a_f02) : (r_a_f02 - r_a_f2);
        n_b_zero = 1'b0;
        unique case (r_mode)
            bgev_pkg::MODE_LOW_PASS: begin
                n_b_num = PW'(r_a_f);
                n_b_den = PW'(fl);
            end
            bgev_pkg::MODE_HIGH_PASS: begin
                n_b_num  = PW'(fl);
                n_b_den  = PW'(r_a_f);
                n_b_zero = (r_a_f == '0);
            end
            bgev_pkg::MODE_BAND_PASS: begin
                n_b_num  = b_diff;
                n_b_den  = r_a_fb;
                n_b_zero = (r_a_fb == '0);
            end
            default: begin
                n_b_num  = r_a_fb;
                n_b_den  = b_diff;
                n_b_zero = (b_diff == '0);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_num  <= n_b_num;
            r_b_den  <= n_b_den;
            r_b_kill <= r_a_err || n_b_zero;
            r_b_err  <= r_a_err;
        end
    end

    // stage c: ratio range check and divider setup
    logic          r_c_valid;
    logic [PW-1:0] r_c_rem;
    logic [31:0]   r_c_num;
    logic [PW-1:0] r_c_den;
    logic          r_c_kill;
    logic          r_c_err;
    logic          c_ovf;

    // integer part of the ratio must stay below 65536
    assign c_ovf = ({16'b0, r_b_num} >= {r_b_den, 16'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_rem  <= PW'(r_b_num >> 16);
            r_c_num  <= {r_b_num[15:0], 16'b0};
            r_c_den  <= r_b_den;
            r_c_kill <= r_b_kill || c_ovf;
            r_c_err  <= r_b_err;
        end
    end

    // ratio divider, q16.16 result
    logic        d1_valid;
    logic [31:0] d1_quo;
    logic [1:0]  d1_side;

    bgev_div #(
        .DEN_W  (PW),
        .Q_BITS (32),
        .SIDE_W (2)
    ) u_ratio_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_valid),
        .i_rem   (r_c_rem),
        .i_den   (r_c_den),
        .i_num   (r_c_num),
        .i_side  ({r_c_err, r_c_kill}),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    // power chain, one multiply per stage
    logic        r_p_valid [0:NPOW-1];
    logic [31:0] r_p       [0:NPOW-1];
    logic [31:0] r_x       [0:NPOW-1];
    logic        r_p_kill  [0:NPOW-1];
    logic        r_p_err   [0:NPOW-1];

    for (genvar k = 0; k < NPOW; k++) begin : g_pow
        logic        in_vld;
        logic [31:0] in_p;
        logic [31:0] in_x;
        logic        in_kill;
        logic        in_err;
        logic [63:0] prod;
        logic        act;
        logic [31:0] n_p;
        logic        n_kill;

        if (k == 0) begin : g_first
            assign in_vld  = d1_valid;
            assign in_p    = 32'h0001_0000;
            assign in_x    = d1_quo;
            assign in_kill = d1_side[0];
            assign in_err  = d1_side[1];
        end else begin : g_next
            assign in_vld  = r_p_valid[k-1];
            assign in_p    = r_p[k-1];
            assign in_x    = r_x[k-1];
            assign in_kill = r_p_kill[k-1];
            assign in_err  = r_p_err[k-1];
        end

        always_comb begin
            prod   = 64'(in_p) * 64'(in_x);
            act    = (6'(k) < two_n) && !in_kill;
            n_p    = in_p;
            n_kill = in_kill;
            if (act) begin
                if (prod[63:48] != 16'b0) begin
                    n_kill = 1'b1;
                end else begin
                    n_p = prod[47:16];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_p_valid[k] <= 1'b0;
            end else if (en) begin
                r_p_valid[k] <= in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_p[k]      <= n_p;
                r_x[k]      <= in_x;
                r_p_kill[k] <= n_kill;
                r_p_err[k]  <= in_err;
            end
        end
    end

    // stage d: 1 + x^(2n)
    logic        r_d_valid;
    logic [32:0] r_d_den;
    logic        r_d_kill;
    logic        r_d_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= r_p_valid[NPOW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_den  <= 33'h0_0001_0000 + {1'b0, r_p[NPOW-1]};
            r_d_kill <= r_p_kill[NPOW-1];
            r_d_err  <= r_p_err[NPOW-1];
        end
    end

    // reciprocal divider, 2^(2g+16) / d
    logic           d2_valid;
    logic [QW2-1:0] d2_quo;
    logic [1:0]     d2_side;

    bgev_div #(
        .DEN_W  (33),
        .Q_BITS (QW2),
        .SIDE_W (2)
    ) u_recip_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_valid),
        .i_rem   (33'h0_0000_8000),
        .i_den   (r_d_den),
        .i_num   ('0),
        .i_side  ({r_d_err, r_d_kill}),
        .o_valid (d2_valid),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    // square root, one result bit per stage
    logic          r_s_valid [0:G];
    logic [VW-1:0] r_s_v     [0:G];
    logic [RW-1:0] r_s_r     [0:G];
    logic [GW-1:0] r_s_q     [0:G];
    logic          r_s_kill  [0:G];
    logic          r_s_err   [0:G];

    for (genvar j = 0; j <= G; j++) begin : g_sqrt
        logic          in_vld;
        logic [VW-1:0] in_v;
        logic [RW-1:0] in_r;
        logic [GW-1:0] in_q;
        logic          in_kill;
        logic          in_err;
        logic [TW-1:0] t;
        logic [TW-1:0] trial;
        logic [TW-1:0] diff;
        logic          ge;

        if (j == 0) begin : g_first
            assign in_vld  = d2_valid;
            assign in_v    = {1'b0, d2_quo};
            assign in_r    = '0;
            assign in_q    = '0;
            assign in_kill = d2_side[0];
            assign in_err  = d2_side[1];
        end else begin : g_next
            assign in_vld  = r_s_valid[j-1];
            assign in_v    = r_s_v[j-1];
            assign in_r    = r_s_r[j-1];
            assign in_q    = r_s_q[j-1];
            assign in_kill = r_s_kill[j-1];
            assign in_err  = r_s_err[j-1];
        end

        always_comb begin
            t     = {in_r, in_v[VW-1:VW-2]};
            trial = {1'b0, in_q, 2'b01};
            diff  = t - trial;
            ge    = (t >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_valid[j] <= 1'b0;
            end else if (en) begin
                r_s_valid[j] <= in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s_v[j]    <= in_v << 2;
                r_s_r[j]    <= ge ? diff[RW-1:0] : t[RW-1:0];
                r_s_q[j]    <= {in_q[GW-2:0], ge};
                r_s_kill[j] <= in_kill;
                r_s_err[j]  <= in_err;
            end
        end
    end

    // output register
    logic [GW-1:0] r_out_gain;
    logic          r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s_valid[G];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_gain <= r_s_kill[G] ? '0 : r_s_q[G];
            r_out_err  <= r_s_err[G];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_gain         = r_out_gain;
    assign o_config_error = r_out_err;

`ifndef ASSERT_OFF
    a_err_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_config_error |-> o_gain == '0)
        else $error("gain not zero on config error");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_gain <= (GW'(1) << G))
        else $error("gain above unity");

    a_transfer_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_a_valid)
        else $error("accepted transfer not captured");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_d_den) && $stable(r_c_valid))
        else $error("pipeline moved during stall");
`endif

endmodule
